### hdl/smta_pkg.sv
// Shared types and codes for the sparse matrix triplet adder.
// Depends on nothing; imported by sparse_matrix_triplet_add_core.
package smta_pkg;

    // Operation codes of an input transfer
    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_START       = 2'd2
    } t_opcode;

    // Merge sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    // One stored triple: row, column, signed value
    typedef struct packed {
        logic [7:0]         row;
        logic [7:0]         column;
        logic signed [15:0] value;
    } t_term;

endpackage

### hdl/sparse_matrix_triplet_add_core.sv
// Sparse matrix triplet adder: two term memories and a merge sequencer.
// Depends on smta_pkg.
//
// Load transfers (opcode 0 or 1) append a (row, column, value) triple to the
// first or second term memory; loads into a full memory are dropped. A start
// transfer (opcode 2) merges the two lists in row-major position order,
// summing values of equal positions (zero sums are kept), and emits one result
// per term with out_last on the final one; both lists are then emptied. A
// start with both lists empty yields a single result with out_empty and
// out_last set. Each merged term passes a fetch state, which reads the heads
// of both memories into registers, and an emit state, which compares, adds
// and registers the result and waits while the output stalls. The input side
// stalls while a merge runs. Memory contents are not cleared by reset; only
// the control registers are: state, fill counts, head indices, out valid.
module sparse_matrix_triplet_add_core #(
    parameter int TERM_CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_term_row,
    input  logic [7:0]         i_term_column,
    input  logic signed [15:0] i_term_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_row,
    output logic [7:0]         o_out_column,
    output logic signed [16:0] o_out_value,
    output logic               o_out_last,
    output logic               o_out_empty
);
    import smta_pkg::*;

    localparam int IDX_W = (TERM_CAPACITY > 1) ? $clog2(TERM_CAPACITY) : 1;
    localparam int CNT_W = $clog2(TERM_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(TERM_CAPACITY);

    // term memories
    t_term mem_first  [TERM_CAPACITY];
    t_term mem_second [TERM_CAPACITY];
    t_term r_rd_first;
    t_term r_rd_second;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt_first, n_cnt_first;
    logic [CNT_W-1:0] r_cnt_second, n_cnt_second;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;

    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_row, n_out_row;
    logic [7:0]         r_out_column, n_out_column;
    logic signed [16:0] r_out_value, n_out_value;
    logic               r_out_last, n_out_last;
    logic               r_out_empty, n_out_empty;

    logic        in_xfer;
    logic        wr_first;
    logic        wr_second;
    logic        out_free;
    logic        have_a;
    logic        have_b;
    logic        take_a;
    logic        take_b;
    logic [15:0] key_a;
    logic [15:0] key_b;
    t_term       in_term;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign in_term.row    = i_term_row;
    assign in_term.column = i_term_column;
    assign in_term.value  = i_term_value;

    // decode loads, drop those into a full memory
    always_comb begin
        wr_first  = 1'b0;
        wr_second = 1'b0;
        if (in_xfer) begin
            unique case (i_opcode)
                OP_LOAD_FIRST:  wr_first  = (r_cnt_first < CAP);
                OP_LOAD_SECOND: wr_second = (r_cnt_second < CAP);
                default: ;
            endcase
        end
    end

    // write appended terms, read list heads
    always_ff @(posedge i_clk) begin
        if (wr_first) begin
            mem_first[r_cnt_first[IDX_W-1:0]] <= in_term;
        end
        if (wr_second) begin
            mem_second[r_cnt_second[IDX_W-1:0]] <= in_term;
        end
        r_rd_first  <= mem_first[r_i[IDX_W-1:0]];
        r_rd_second <= mem_second[r_j[IDX_W-1:0]];
    end

    // compare the two heads
    assign have_a = (r_i < r_cnt_first);
    assign have_b = (r_j < r_cnt_second);
    assign key_a  = {r_rd_first.row, r_rd_first.column};
    assign key_b  = {r_rd_second.row, r_rd_second.column};

    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        priority if (have_a && have_b) begin
            take_a = (key_a <= key_b);
            take_b = (key_b <= key_a);
        end else if (have_a) begin
            take_a = 1'b1;
        end else if (have_b) begin
            take_b = 1'b1;
        end
    end

    // sequencer and output register
    always_comb begin
        n_state      = r_state;
        n_cnt_first  = r_cnt_first + CNT_W'(wr_first);
        n_cnt_second = r_cnt_second + CNT_W'(wr_second);
        n_i          = r_i;
        n_j          = r_j;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_row    = r_out_row;
        n_out_column = r_out_column;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        unique case (r_state)
            ST_IDLE: begin
                n_i = '0;
                n_j = '0;
                if (in_xfer && (i_opcode == OP_START)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_i          = r_i + CNT_W'(take_a);
                    n_j          = r_j + CNT_W'(take_b);
                    n_out_valid  = 1'b1;
                    n_out_empty  = !have_a && !have_b;
                    n_out_last   = (n_i >= r_cnt_first) && (n_j >= r_cnt_second);
                    // zero position when neither list holds a term
                    n_out_row    = take_a ? r_rd_first.row
                                 : (take_b ? r_rd_second.row : 8'd0);
                    n_out_column = take_a ? r_rd_first.column
                                 : (take_b ? r_rd_second.column : 8'd0);
                    n_out_value  = (take_a ? 17'(r_rd_first.value) : 17'sd0)
                                 + (take_b ? 17'(r_rd_second.value) : 17'sd0);
                    if (n_out_last) begin
                        n_cnt_first  = '0;
                        n_cnt_second = '0;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // advance state; control cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_first  <= n_cnt_first;
            r_cnt_second <= n_cnt_second;
            r_i          <= n_i;
            r_j          <= n_j;
            r_out_valid  <= n_out_valid;
        end
        r_out_row    <= n_out_row;
        r_out_column <= n_out_column;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
        r_out_empty  <= n_out_empty;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_row    = r_out_row;
    assign o_out_column = r_out_column;
    assign o_out_value  = r_out_value;
    assign o_out_last   = r_out_last;
    assign o_out_empty  = r_out_empty;

endmodule

### tb/tb_sparse_matrix_triplet_add_core.sv
// Testbench for sparse_matrix_triplet_add_core: directed and random load/start
// traffic, checked against an in-bench merge predictor. Depends on smta_pkg.
`timescale 1ns / 1ps

module tb_sparse_matrix_triplet_add_core;
    import smta_pkg::*;

    localparam int          CAPACITY      = 16;
    localparam int          WATCHDOG_IDLE = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;

    // One expected sum term
    typedef struct {
        logic [7:0]         row;
        logic [7:0]         column;
        logic signed [16:0] value;
        logic               last;
        logic               empty;
    } t_sum_term;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode      = 2'd0;
    logic [7:0]         i_term_row    = 8'd0;
    logic [7:0]         i_term_column = 8'd0;
    logic signed [15:0] i_term_value  = 16'sd0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [7:0]         o_out_row;
    logic [7:0]         o_out_column;
    logic signed [16:0] o_out_value;
    logic               o_out_last;
    logic               o_out_empty;

    // Predictor state: the two loaded lists and the pending sum terms
    t_term     first_terms[$];
    t_term     second_terms[$];
    t_sum_term pending_sums[$];

    int mismatches    = 0;
    int items_sent    = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    sparse_matrix_triplet_add_core #(
        .TERM_CAPACITY(CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_term_row   (i_term_row),
        .i_term_column(i_term_column),
        .i_term_value (i_term_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_row    (o_out_row),
        .o_out_column (o_out_column),
        .o_out_value  (o_out_value),
        .o_out_last   (o_out_last),
        .o_out_empty  (o_out_empty)
    );

    always #5 i_clk = ~i_clk;

    // Apply one accepted transfer to the lists; a start queues the merged sum
    function automatic void predict_transfer(logic [1:0] op, logic [7:0] row,
                                             logic [7:0] column, logic signed [15:0] value);
        t_term     term;
        t_sum_term sum;
        int        i;
        int        j;
        int        first_n;
        logic [15:0] key_a;
        logic [15:0] key_b;
        term.row    = row;
        term.column = column;
        term.value  = value;
        case (op)
            OP_LOAD_FIRST: begin
                if (first_terms.size() < CAPACITY) first_terms.push_back(term);
            end
            OP_LOAD_SECOND: begin
                if (second_terms.size() < CAPACITY) second_terms.push_back(term);
            end
            OP_START: begin
                sum.last  = 1'b0;
                sum.empty = 1'b0;
                first_n   = pending_sums.size();
                i = 0;
                j = 0;
                if (first_terms.size() == 0 && second_terms.size() == 0) begin
                    sum.row    = 8'd0;
                    sum.column = 8'd0;
                    sum.value  = 17'sd0;
                    sum.empty  = 1'b1;
                    pending_sums.push_back(sum);
                end
                // Merge heads by row-major position, summing equal positions
                while (i < first_terms.size() && j < second_terms.size()) begin
                    key_a = {first_terms[i].row, first_terms[i].column};
                    key_b = {second_terms[j].row, second_terms[j].column};
                    if (key_a < key_b) begin
                        sum.row    = first_terms[i].row;
                        sum.column = first_terms[i].column;
                        sum.value  = $signed(first_terms[i].value);
                        i++;
                    end else if (key_a > key_b) begin
                        sum.row    = second_terms[j].row;
                        sum.column = second_terms[j].column;
                        sum.value  = $signed(second_terms[j].value);
                        j++;
                    end else begin
                        sum.row    = first_terms[i].row;
                        sum.column = first_terms[i].column;
                        sum.value  = $signed(first_terms[i].value)
                                   + $signed(second_terms[j].value);
                        i++;
                        j++;
                    end
                    pending_sums.push_back(sum);
                end
                // Flush leftovers of either list
                while (i < first_terms.size()) begin
                    sum.row    = first_terms[i].row;
                    sum.column = first_terms[i].column;
                    sum.value  = $signed(first_terms[i].value);
                    pending_sums.push_back(sum);
                    i++;
                end
                while (j < second_terms.size()) begin
                    sum.row    = second_terms[j].row;
                    sum.column = second_terms[j].column;
                    sum.value  = $signed(second_terms[j].value);
                    pending_sums.push_back(sum);
                    j++;
                end
                if (pending_sums.size() > first_n)
                    pending_sums[pending_sums.size() - 1].last = 1'b1;
                first_terms.delete();
                second_terms.delete();
            end
            default: ;
        endcase
    endfunction

    // Observe both channels: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_sum_term exp_sum;
        if (i_rst_n && i_in_valid && !o_in_stall)
            predict_transfer(i_opcode, i_term_row, i_term_column, i_term_value);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: row %0d col %0d val %0d last %b empty %b",
                             o_out_row, o_out_column, o_out_value, o_out_last, o_out_empty);
            end else begin
                exp_sum = pending_sums.pop_front();
                if (o_out_row !== exp_sum.row || o_out_column !== exp_sum.column
                        || o_out_value !== exp_sum.value || o_out_last !== exp_sum.last
                        || o_out_empty !== exp_sum.empty) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"result mismatch: expected row %0d col %0d val %0d",
                                  " last %b empty %b, got row %0d col %0d val %0d",
                                  " last %b empty %b"},
                                 exp_sum.row, exp_sum.column, exp_sum.value, exp_sum.last,
                                 exp_sum.empty, o_out_row, o_out_column, o_out_value,
                                 o_out_last, o_out_empty);
                end
            end
        end
    end

    // Drive output stall: a requested hold-off first, else random stalls
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_IDLE) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one item after a random idle gap and hold it until the transfer
    task automatic send_item(logic [1:0] op, logic [7:0] row, logic [7:0] column,
                             logic signed [15:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_term_row    <= row;
        i_term_column <= column;
        i_term_value  <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering and wait until every queued sum term has come out
    task automatic wait_sums_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Start with both lists empty
    task automatic test_empty_start();
        send_item(OP_START, 8'hFF, 8'hFF, 16'sh7FFF);
    endtask

    // Extreme values, equal positions with overflow-free and zero sums,
    // unused opcode ignored in the middle of a set
    task automatic test_extremes();
        send_item(OP_LOAD_FIRST,  8'd0,   8'd0,   16'sh7FFF);
        send_item(OP_LOAD_SECOND, 8'd0,   8'd0,   16'sh7FFF);
        send_item(OP_LOAD_FIRST,  8'd0,   8'd1,   16'sh8000);
        send_item(OP_LOAD_SECOND, 8'd0,   8'd1,   16'sh8000);
        send_item(OP_LOAD_FIRST,  8'd128, 8'd7,   16'sh7FFF);
        send_item(OP_LOAD_SECOND, 8'd128, 8'd7,   16'sh8001);
        send_item(OP_UNUSED,      8'hFF,  8'hFF,  16'shFFFF);
        send_item(OP_LOAD_SECOND, 8'd255, 8'd254, 16'sd1);
        send_item(OP_LOAD_FIRST,  8'd255, 8'd255, 16'sh8000);
        send_item(OP_START,       8'd0,   8'd0,   16'sd0);
    endtask

    // Only the second list holds terms
    task automatic test_second_only();
        send_item(OP_LOAD_SECOND, 8'd3, 8'd200, -16'sd5);
        send_item(OP_LOAD_SECOND, 8'd9, 8'd1,   16'sd77);
        send_item(OP_START,       8'd0, 8'd0,   16'sd0);
    endtask

    // Overfill the first list with descending positions: extra load dropped,
    // out-of-order list passed through as loaded
    task automatic test_full_store();
        int n;
        for (n = 0; n <= CAPACITY; n++)
            send_item(OP_LOAD_FIRST, 8'(250 - 13 * n), 8'(17 * n), 16'($urandom));
        send_item(OP_START, 8'd0, 8'd0, 16'sd0);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One load set and its start: sorted positions shared between lists,
    // or raw noise with any opcode
    task automatic send_merge_set(bit well_formed);
        int          n;
        int          k;
        int          key;
        int          route;
        logic [15:0] val;
        n   = ($urandom_range(7) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 10);
        key = $urandom_range(0, 3000);
        for (k = 0; k < n; k++) begin
            val = pick_value();
            if (!well_formed) begin
                send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom), val);
            end else begin
                if (key > 16'hFFFF) break;
                route = $urandom_range(2);
                if (route != 1)
                    send_item(OP_LOAD_FIRST, key[15:8], key[7:0], val);
                if (route == 2 && $urandom_range(3) == 0)
                    val = -val;
                else if (route != 0)
                    val = pick_value();
                if (route != 0)
                    send_item(OP_LOAD_SECOND, key[15:8], key[7:0], val);
                key += $urandom_range(1, 6000);
            end
        end
        send_item(OP_START, 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    // Random sets under one idling pattern
    task automatic test_random_phase(int sender_idle, int receiver_stall, int count);
        int stop_at;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        stop_at   = items_sent + count;
        while (items_sent < stop_at)
            send_merge_set($urandom_range(4) != 0);
    endtask

    // Hold the result channel off during a merge while loads keep coming
    task automatic test_backpressure();
        int k;
        idle_pct  = 0;
        stall_pct = 0;
        for (k = 0; k < 6; k++) begin
            send_item(OP_LOAD_FIRST,  8'(2 * k), 8'(k), 16'($urandom));
            send_item(OP_LOAD_SECOND, 8'(2 * k + 1), 8'(k), 16'($urandom));
        end
        hold_request = 150;
        send_item(OP_START, 8'd0, 8'd0, 16'sd0);
        for (k = 0; k < 6; k++)
            send_item(OP_LOAD_FIRST, 8'(40 + k), 8'(k), 16'($urandom));
        send_item(OP_START, 8'd0, 8'd0, 16'sd0);
        wait_sums_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_start();
        test_extremes();
        test_second_only();
        test_full_store();
        wait_sums_drained();

        test_random_phase(0, 0, 10);
        test_random_phase(66, 0, 10);
        test_backpressure();
        test_random_phase(0, 66, 10);
        test_random_phase(38, 38, 10);

        // Drain remaining results, then let the block settle
        wait_sums_drained();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
